/* design/lfu_pkg.sv */
// shared types and constants for the lfu cache store
package lfu_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned CapW     = 5;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  localparam logic FuncGet = 1'b0;
  localparam logic FuncPut = 1'b1;

  localparam logic [KeyW-1:0] MissValue  = '1;
  localparam logic [KeyW-1:0] CountMax   = '1;
  localparam logic [KeyW-1:0] CountFirst = KeyW'(1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPD,
    ST_RESP
  } state_e;

endpackage

/* design/lfu_ram.sv */
// generic simple dual port ram with registered read
module lfu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/lfu_cache_store_unit.sv */
// top level of the lfu cache store with lru tie-break
//
// usage: one request on the input channel (func, lookup_key, write_value) gives
// exactly one result on the output channel (hit, read_value, evicted,
// evicted_key). func selects get or put. a get miss answers -1, a put miss 0.
// the capacity register is written through its own valid/ready channel, which
// is always ready; write it only while no request is in flight.
// all slots live in one ram, one word per slot, read one slot a cycle.
// a request runs a lookup scan over every slot and a decision, then a
// read-modify-write pass that updates ranks and counts when the request hits
// or inserts, then hands the result over; a new request is taken only after
// the last one has handed its result to the output register.
// with capacity zero a request skips the scan and the update pass.
// after reset a clearing pass writes every slot invalid, while no request is
// taken; capacity writes are still accepted.
// the result sits in an output register; if the receiver stalls, the next
// request can still be taken and runs until its result is ready to hand over.
module lfu_cache_store_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic signed [lfu_pkg::KeyW-1:0]   lookup_key_i,
  input  logic signed [lfu_pkg::KeyW-1:0]   write_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic signed [lfu_pkg::KeyW-1:0]   read_value_o,
  output logic                              evicted_o,
  output logic signed [lfu_pkg::KeyW-1:0]   evicted_key_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lfu_pkg::CapW-1:0]          capacity_limit_i
);

  localparam int unsigned KeyW  = lfu_pkg::KeyW;
  localparam int unsigned CapW  = lfu_pkg::CapW;
  localparam int unsigned IdxW  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned OccW  = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW  = OccW > CapW ? OccW : CapW;
  localparam logic [CntW-1:0] LastCnt = CntW'(ENTRIES);
  localparam logic [OccW-1:0] OccMax  = OccW'(ENTRIES);
  localparam logic [CmpW-1:0] CapMax  = CmpW'(ENTRIES);

  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [KeyW-1:0]  value;
    logic [KeyW-1:0]  count;
    logic [RankW-1:0] rank;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  lfu_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] prev_idx_q;

  logic [CapW-1:0] cap_q;
  logic [OccW-1:0] occ_q;

  logic            req_put_q;
  logic [KeyW-1:0] req_key_q, req_val_q;

  logic             found_q, free_q, vic_q;
  logic [IdxW-1:0]  found_idx_q, free_idx_q, vic_idx_q;
  logic [RankW-1:0] found_rank_q, vic_rank_q;
  logic [KeyW-1:0]  found_val_q, vic_cnt_q, vic_key_q;

  logic            evict_q, insert_q;
  logic [IdxW-1:0] tgt_idx_q;

  logic            res_hit_q, res_evict_q;
  logic [KeyW-1:0] res_val_q, res_key_q;

  logic            out_valid_q, out_hit_q, out_evict_q;
  logic [KeyW-1:0] out_val_q, out_key_q;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  slot_t           ram_wdata, ram_rdata, upd_word;
  logic [SlotW-1:0] ram_rbits;

  logic            accept, proc, out_load;
  logic [CmpW-1:0] eff_cap;
  logic            cap_zero, occ_full, evict_c, insert_c, need_upd;

  assign ram_rdata = slot_t'(ram_rbits);

  lfu_ram #(
    .Width (SlotW),
    .Depth (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == lfu_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign proc        = (cnt_q != '0);
  assign out_load    = (state_q == lfu_pkg::ST_RESP) && (!out_valid_q || out_ready_i);

  assign eff_cap  = (CmpW'(cap_q) > CapMax) ? CapMax : CmpW'(cap_q);
  assign cap_zero = (cap_q == '0);
  assign occ_full = (CmpW'(occ_q) >= eff_cap);
  assign evict_c  = req_put_q && !found_q && (occ_full || !free_q) && vic_q && !cap_zero;
  assign insert_c = req_put_q && !found_q && (evict_c || free_q) && !cap_zero;
  assign need_upd = found_q || insert_c;

  // new slot word for the update pass
  always_comb begin
    upd_word = ram_rdata;
    if (found_q) begin
      if (prev_idx_q == found_idx_q) begin
        if (req_put_q) begin
          upd_word.value = req_val_q;
        end
        if (ram_rdata.count != lfu_pkg::CountMax) begin
          upd_word.count = ram_rdata.count + KeyW'(1);
        end
        upd_word.rank = '0;
      end else if (ram_rdata.valid && ram_rdata.rank < found_rank_q) begin
        upd_word.rank = ram_rdata.rank + RankW'(1);
      end
    end else if (insert_q) begin
      if (prev_idx_q == tgt_idx_q) begin
        upd_word.valid = 1'b1;
        upd_word.key   = req_key_q;
        upd_word.value = req_val_q;
        upd_word.count = lfu_pkg::CountFirst;
        upd_word.rank  = '0;
      end else if (ram_rdata.valid && !(evict_q && ram_rdata.rank > vic_rank_q)) begin
        upd_word.rank = ram_rdata.rank + RankW'(1);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_q[IdxW-1:0];
    ram_raddr = cnt_q[IdxW-1:0];
    ram_wdata = upd_word;
    case (state_q)
      lfu_pkg::ST_CLEAR: begin
        ram_we          = 1'b1;
        ram_wdata       = '0;
        ram_wdata.valid = 1'b0;
        if (cnt_q == LastCnt - CntW'(1)) begin
          cnt_d   = '0;
          state_d = lfu_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      lfu_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cap_zero ? lfu_pkg::ST_DECIDE : lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        ram_re = (cnt_q < LastCnt);
        if (cnt_q == LastCnt) begin
          cnt_d   = '0;
          state_d = lfu_pkg::ST_DECIDE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      lfu_pkg::ST_DECIDE: begin
        state_d = need_upd ? lfu_pkg::ST_UPD : lfu_pkg::ST_RESP;
      end
      lfu_pkg::ST_UPD: begin
        ram_re    = (cnt_q < LastCnt);
        ram_we    = proc;
        ram_waddr = prev_idx_q;
        if (cnt_q == LastCnt) begin
          cnt_d   = '0;
          state_d = lfu_pkg::ST_RESP;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      lfu_pkg::ST_RESP: begin
        if (out_load) begin
          state_d = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfu_pkg::ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lfu_pkg::CapReset;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= capacity_limit_i;
      end
      if (state_q == lfu_pkg::ST_DECIDE && insert_c && !evict_c && occ_q != OccMax) begin
        occ_q <= occ_q + OccW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture, scan results, decision and output register load
  always_ff @(posedge clk_i) begin
    prev_idx_q <= cnt_q[IdxW-1:0];
    if (accept) begin
      req_put_q <= (func_i == lfu_pkg::FuncPut);
      req_key_q <= lookup_key_i;
      req_val_q <= write_value_i;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      vic_q     <= 1'b0;
    end
    if (state_q == lfu_pkg::ST_SCAN && proc) begin
      if (ram_rdata.valid) begin
        if (!found_q && ram_rdata.key == req_key_q) begin
          found_q      <= 1'b1;
          found_idx_q  <= prev_idx_q;
          found_rank_q <= ram_rdata.rank;
          found_val_q  <= ram_rdata.value;
        end
        if (!vic_q || ram_rdata.count < vic_cnt_q ||
            (ram_rdata.count == vic_cnt_q && ram_rdata.rank > vic_rank_q)) begin
          vic_q      <= 1'b1;
          vic_idx_q  <= prev_idx_q;
          vic_cnt_q  <= ram_rdata.count;
          vic_rank_q <= ram_rdata.rank;
          vic_key_q  <= ram_rdata.key;
        end
      end else if (!free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= prev_idx_q;
      end
    end
    if (state_q == lfu_pkg::ST_DECIDE) begin
      evict_q     <= evict_c;
      insert_q    <= insert_c;
      tgt_idx_q   <= evict_c ? vic_idx_q : free_idx_q;
      res_hit_q   <= found_q;
      res_evict_q <= evict_c;
      res_key_q   <= evict_c ? vic_key_q : '0;
      if (found_q) begin
        res_val_q <= req_put_q ? req_val_q : found_val_q;
      end else begin
        res_val_q <= req_put_q ? '0 : lfu_pkg::MissValue;
      end
    end
    if (out_load) begin
      out_hit_q   <= res_hit_q;
      out_evict_q <= res_evict_q;
      out_val_q   <= res_val_q;
      out_key_q   <= res_key_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign evicted_o     = out_evict_q;
  assign read_value_o  = out_val_q;
  assign evicted_key_o = out_key_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccMax)
    else $error("occupancy above slot count");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o)
    else $error("eviction reported on a hit");

  a_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_key_o == '0)
    else $error("evicted key set without eviction");

  a_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == lfu_pkg::ST_CLEAR || state_q == lfu_pkg::ST_UPD))
    else $error("slot write outside clear or update pass");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request taken while one is in flight");

endmodule

/* dv/tb_lfu_cache_store_unit.sv */
// testbench for lfu_cache_store_unit: directed table then random traffic, checked by a predictor
`timescale 1ns / 1ps

module tb_lfu_cache_store_unit;

  localparam int unsigned KeyW = lfu_pkg::KeyW;
  localparam int unsigned CapW = lfu_pkg::CapW;
  localparam logic [CapW-1:0] CapReset = lfu_pkg::CapReset;
  localparam logic FuncGet = lfu_pkg::FuncGet;
  localparam logic FuncPut = lfu_pkg::FuncPut;
  localparam logic [KeyW-1:0] MissValue  = lfu_pkg::MissValue;
  localparam logic [KeyW-1:0] CountMax   = lfu_pkg::CountMax;
  localparam logic [KeyW-1:0] CountFirst = lfu_pkg::CountFirst;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned PoolSize = 24;
  localparam int unsigned ItemsPerPhase = 105;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned NumRows = 27;
  localparam int unsigned OutHoldCycles = 400;
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic            hit;
    logic [KeyW-1:0] value;
    logic            evicted;
    logic [KeyW-1:0] ev_key;
  } lfu_resp_t;

  typedef enum logic {ROW_OP, ROW_CAP} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [CapW-1:0] cap;
    logic            func;
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] val;
    logic            typed;
    lfu_resp_t       resp;
  } row_t;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     func_i = FuncGet;
  logic signed [KeyW-1:0]   lookup_key_i = '0;
  logic signed [KeyW-1:0]   write_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     hit_o;
  logic signed [KeyW-1:0]   read_value_o;
  logic                     evicted_o;
  logic signed [KeyW-1:0]   evicted_key_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CapW-1:0]          capacity_limit_i = CapReset;

  // predictor state
  logic [CapW-1:0] cap_reg = CapReset;
  logic            slot_vld [ENTRIES];
  logic [KeyW-1:0] slot_k   [ENTRIES];
  logic [KeyW-1:0] slot_v   [ENTRIES];
  logic [KeyW-1:0] slot_cnt [ENTRIES];
  int unsigned     slot_age [ENTRIES];
  int unsigned     occ = 0;

  lfu_resp_t       lookup_answer_q [$];
  int unsigned     err_cnt = 0;
  int unsigned     cycle_cnt = 0;
  int unsigned     hold_req_cnt = 0;
  logic [KeyW-1:0] key_pool [PoolSize];
  logic [CapW-1:0] phase_caps [NumPhases];
  row_t            dir_rows [NumRows];

  lfu_cache_store_unit #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .lookup_key_i    (lookup_key_i),
    .write_value_i   (write_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .read_value_o    (read_value_o),
    .evicted_o       (evicted_o),
    .evicted_key_o   (evicted_key_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .capacity_limit_i(capacity_limit_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic lfu_resp_t lfu_access(logic fn, logic [KeyW-1:0] key,
                                           logic [KeyW-1:0] val);
    lfu_resp_t   r;
    int          found;
    int          free_slot;
    int          victim;
    int unsigned cap_eff;
    int unsigned rk;
    r.hit     = 1'b0;
    r.value   = (fn == FuncPut) ? '0 : MissValue;
    r.evicted = 1'b0;
    r.ev_key  = '0;
    cap_eff   = (32'(cap_reg) > ENTRIES) ? ENTRIES : 32'(cap_reg);
    if (cap_eff == 0) return r;
    found     = -1;
    free_slot = -1;
    victim    = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_vld[i]) begin
        if (found < 0 && slot_k[i] == key) found = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (found >= 0) begin
      if (fn == FuncPut) slot_v[found] = val;
      if (slot_cnt[found] != CountMax) slot_cnt[found]++;
      rk = slot_age[found];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_vld[i] && i != found && slot_age[i] < rk) slot_age[i]++;
      slot_age[found] = 0;
      r.hit   = 1'b1;
      r.value = slot_v[found];
      return r;
    end
    if (fn == FuncGet) return r;
    if (occ >= cap_eff || free_slot < 0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_vld[i]) continue;
        if (victim < 0 || slot_cnt[i] < slot_cnt[victim] ||
            (slot_cnt[i] == slot_cnt[victim] && slot_age[i] > slot_age[victim]))
          victim = i;
      end
    end
    if (victim >= 0) begin
      rk        = slot_age[victim];
      r.evicted = 1'b1;
      r.ev_key  = slot_k[victim];
      slot_vld[victim] = 1'b0;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_vld[i] && slot_age[i] > rk) slot_age[i]--;
      if (occ > 0) occ--;
      free_slot = victim;
    end
    if (free_slot < 0) return r;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_vld[i]) slot_age[i]++;
    slot_vld[free_slot] = 1'b1;
    slot_k[free_slot]   = key;
    slot_v[free_slot]   = val;
    slot_cnt[free_slot] = CountFirst;
    slot_age[free_slot] = 0;
    if (occ < ENTRIES) occ++;
    return r;
  endfunction

  task automatic offer_request(input logic fn, input logic [KeyW-1:0] key,
                               input logic [KeyW-1:0] val, input logic typed,
                               input lfu_resp_t typed_resp);
    lfu_resp_t pr;
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    lookup_key_i  <= key;
    write_value_i <= val;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pr = lfu_access(fn, key, val);
    if (typed) pr = typed_resp;
    lookup_answer_q = {lookup_answer_q, pr};
  endtask

  task automatic wait_answers_drained();
    while (lookup_answer_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] v);
    in_valid_i <= 1'b0;
    wait_answers_drained();
    repeat (4) @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    capacity_limit_i <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_reg = v;
  endtask

  task automatic cmp_field(input string name, input logic [KeyW-1:0] want,
                           input logic [KeyW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // result checker
  initial begin
    lfu_resp_t got;
    lfu_resp_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{hit_o, read_value_o, evicted_o, evicted_key_o};
        if (lookup_answer_q.size() == 0) begin
          $display("%0t: unrequested result, expected none, got %h", $time, got);
          err_cnt++;
        end else begin
          want = lookup_answer_q.pop_front();
          cmp_field("hit", KeyW'(want.hit), KeyW'(got.hit));
          cmp_field("read_value", want.value, got.value);
          cmp_field("evicted", KeyW'(want.evicted), KeyW'(got.evicted));
          cmp_field("evicted_key", want.ev_key, got.ev_key);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    rx_mode_e    mode;
    int unsigned left;
    int unsigned period;
    int unsigned duty;
    int unsigned tick;
    int unsigned hold_seen;
    mode      = RX_STEADY;
    left      = 0;
    period    = 2;
    duty      = 1;
    tick      = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        out_ready_i <= 1'b0;
        repeat (OutHoldCycles - 1) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode   = rx_mode_e'($urandom_range(0, 2));
          left   = $urandom_range(32, 256);
          period = $urandom_range(2, 9);
          duty   = $urandom_range(1, period - 1);
        end
        left--;
        tick++;
        case (mode)
          RX_STEADY: out_ready_i <= 1'b1;
          RX_RANDOM: out_ready_i <= ($urandom_range(0, 9) < 6);
          default:   out_ready_i <= ((tick % period) < duty);
        endcase
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_lfu_cache_store_unit: done, errors");
    $finish;
  end

  initial begin
    int unsigned     psz;
    int unsigned     cap_eff;
    int unsigned     burst;
    int unsigned     gap;
    logic            fn;
    logic [KeyW-1:0] key;

    for (int i = 0; i < ENTRIES; i++) begin
      slot_vld[i] = 1'b0;
      slot_k[i]   = '0;
      slot_v[i]   = '0;
      slot_cnt[i] = '0;
      slot_age[i] = 0;
    end

    dir_rows = '{
      '{ROW_OP, 5'd0, FuncGet, 32'h0000_0000, 32'h0, 1'b1, '{1'b0, MissValue, 1'b0, 32'h0}},
      '{ROW_OP, 5'd0, FuncPut, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_OP, 5'd0, FuncGet, 32'h8000_0000, 32'h0, 1'b1,
        '{1'b1, 32'h7fff_ffff, 1'b0, 32'h0}},
      '{ROW_OP, 5'd0, FuncPut, 32'h7fff_ffff, 32'h8000_0000, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_OP, 5'd0, FuncPut, 32'h7fff_ffff, 32'hffff_ffff, 1'b1,
        '{1'b1, 32'hffff_ffff, 1'b0, 32'h0}},
      '{ROW_OP, 5'd0, FuncGet, 32'h7fff_ffff, 32'h0, 1'b1,
        '{1'b1, 32'hffff_ffff, 1'b0, 32'h0}},
      '{ROW_OP, 5'd0, FuncGet, 32'hffff_ffff, 32'h0, 1'b1, '{1'b0, MissValue, 1'b0, 32'h0}},
      '{ROW_CAP, 5'd2, FuncGet, 32'h0, 32'h0, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_0005, 32'h0000_0011, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_0006, 32'h0000_0022, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncGet, 32'h0000_0006, 32'h0, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_0007, 32'h0000_0033, 1'b0, '0},
      '{ROW_CAP, 5'd3, FuncGet, 32'h0, 32'h0, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_0008, 32'h0000_0044, 1'b0, '0},
      // equal counts, least recent goes
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_0009, 32'h0000_0055, 1'b0, '0},
      '{ROW_CAP, 5'd0, FuncGet, 32'h0, 32'h0, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncGet, 32'h0000_0008, 32'h0, 1'b1, '{1'b0, MissValue, 1'b0, 32'h0}},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_000a, 32'h0000_0066, 1'b1,
        '{1'b0, 32'h0, 1'b0, 32'h0}},
      // above the slot count, saturates
      '{ROW_CAP, 5'd31, FuncGet, 32'h0, 32'h0, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncGet, 32'h0000_0008, 32'h0, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_000b, 32'h0000_0077, 1'b0, '0},
      // limit below occupancy
      '{ROW_CAP, 5'd1, FuncGet, 32'h0, 32'h0, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_000c, 32'h0000_0088, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncGet, 32'h0000_0009, 32'h0, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_000d, 32'h0000_0099, 1'b0, '0},
      '{ROW_OP, 5'd0, FuncPut, 32'h0000_000d, 32'h0000_00aa, 1'b0, '0},
      '{ROW_CAP, 5'd16, FuncGet, 32'h0, 32'h0, 1'b0, '0}
    };

    phase_caps = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd9, 5'd17, 5'd2, 5'd16, 5'd12};
    phase_caps[8] = CapW'($urandom_range(0, 31));

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < PoolSize; i++) key_pool[i] = $urandom;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        write_capacity(dir_rows[i].cap);
      end else begin
        offer_request(dir_rows[i].func, dir_rows[i].key, dir_rows[i].val,
                      dir_rows[i].typed, dir_rows[i].resp);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      write_capacity(phase_caps[p]);
      for (int i = 0; i < 4; i++) key_pool[$urandom_range(4, PoolSize - 1)] = $urandom;
      cap_eff = (32'(phase_caps[p]) > ENTRIES) ? ENTRIES : 32'(phase_caps[p]);
      psz     = cap_eff + $urandom_range(1, 6);
      if (psz > PoolSize) psz = PoolSize;
      burst = $urandom_range(1, 20);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ((p == 0 && n == 20) || (p == 5 && n == 40)) hold_req_cnt++;
        if (p == 3 && n == 50) begin
          in_valid_i <= 1'b0;
          wait_answers_drained();
        end
        fn  = ($urandom_range(0, 9) < 6) ? FuncPut : FuncGet;
        key = ($urandom_range(0, 15) == 0) ? KeyW'($urandom)
                                           : key_pool[$urandom_range(0, psz - 1)];
        offer_request(fn, key, $urandom, 1'b0, '0);
        burst--;
        if (burst == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          if (gap > 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst = $urandom_range(1, 20);
        end
      end
    end

    in_valid_i <= 1'b0;
    wait_answers_drained();
    repeat (2 * ENTRIES + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_lfu_cache_store_unit: done, clean");
    end else begin
      $display("tb_lfu_cache_store_unit: done, errors");
    end
    $finish;
  end

endmodule
